### hw/rtl/sphere_contact_penalty_force_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sphere contact penalty force block.
// Both macros expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef SPHERE_CONTACT_PENALTY_FORCE_MACROS_SVH
`define SPHERE_CONTACT_PENALTY_FORCE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SCPF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/scpf_pkg.sv
// ----------------------------------------------------------------------------
// scpf_pkg
// Widths, stage counts, register indexes and shared types of the sphere
// contact penalty force pipeline.
// ----------------------------------------------------------------------------
package scpf_pkg;

    localparam int COORD_W     = 18;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 37;
    localparam int SUM_W       = 39;
    localparam int RAD_W       = 16;
    localparam int RSUM_W      = RAD_W + 1;
    localparam int MAG_W       = RSUM_W;
    localparam int S_W         = 2 * RSUM_W;
    localparam int LEN_W       = RSUM_W + 8;
    localparam int SQRT_STAGES = LEN_W;
    localparam int SQRT_W      = 2 * SQRT_STAGES + 1;
    localparam int KP_W        = RAD_W + LEN_W;
    localparam int NUM_W       = KP_W + MAG_W;
    localparam int NUMER_W     = NUM_W + 2;
    localparam int DEN_W       = LEN_W + 13;
    localparam int FORCE_W     = 24;
    localparam int DIV_STAGES  = FORCE_W;
    localparam int REM_W       = DEN_W + DIV_STAGES;
    localparam int AXIS_LAT    = 5 + DIV_STAGES + 1;
    localparam int CFG_IDX_W   = 2;

    localparam logic [RAD_W-1:0] TOOL_RADIUS_RST = 16'd6554;
    localparam logic [RAD_W-1:0] NODE_RADIUS_RST = 16'd3277;
    localparam logic [RAD_W-1:0] STIFFNESS_RST   = 16'd25600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOOL_RADIUS = 2'd0,
        REG_NODE_RADIUS = 2'd1,
        REG_STIFFNESS   = 2'd2
    } cfg_reg_t;

    // Per item geometry that leaves the front end.
    typedef struct packed {
        logic                   contact;
        logic [2:0]             neg;
        logic [2:0][MAG_W-1:0]  mag;
        logic [S_W-1:0]         s;
    } geom_t;

endpackage

### hw/rtl/sphere_contact_penalty_force.sv
// ----------------------------------------------------------------------------
// sphere_contact_penalty_force
// Penalty contact force between a tool sphere and a node sphere.
// ----------------------------------------------------------------------------
// Each request on the s_ side carries the tool and node centers; the block
// returns one request on the m_ side with the force on the tool along x, y
// and z and an in_contact flag. Forces are zero whenever in_contact is low.
// Radii and stiffness are to be written through the cfg_ port only while no
// request is in flight; the block does not enforce this. They reset to
// 6554, 3277 and 25600. The pipeline runs the difference and overlap test,
// the square root (one bit per stage), and per axis penetration, two
// multiplies, rounding setup, 24 divider stages and saturation.
// Throughput is one request per cycle. The whole pipeline advances together;
// when the output holds a request that the receiver does not take, every
// stage holds and s_tready drops in the same cycle, so nothing is lost or
// repeated. Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "sphere_contact_penalty_force_macros.svh"

module sphere_contact_penalty_force (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [scpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scpf_pkg::RAD_W-1:0]          cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tool_x, tool_y, tool_z, node_x, node_y, node_z, zero pad
    input  logic [111:0]                        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // force_x, force_y, force_z, in_contact, zero pad
    output logic [79:0]                         m_tdata
);

    localparam int CW = scpf_pkg::COORD_W;
    localparam int L  = scpf_pkg::AXIS_LAT;

    logic [scpf_pkg::RAD_W-1:0]                 tool_radius_reg;
    logic [scpf_pkg::RAD_W-1:0]                 node_radius_reg;
    logic [scpf_pkg::RAD_W-1:0]                 stiffness_reg;
    logic [scpf_pkg::RSUM_W-1:0]                rsum;
    logic                                       pipe_en;
    logic [2:0][CW-1:0]                         tool, node;
    logic                                       front_valid, sqrt_valid;
    scpf_pkg::geom_t                            front_geom, sqrt_geom;
    logic [scpf_pkg::LEN_W-1:0]                 len;
    logic [2:0][scpf_pkg::FORCE_W-1:0]          force_v;
    logic [L-1:0]                               vld_reg;
    logic [L-1:0]                               contact_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tool_radius_reg <= scpf_pkg::TOOL_RADIUS_RST;
            node_radius_reg <= scpf_pkg::NODE_RADIUS_RST;
            stiffness_reg   <= scpf_pkg::STIFFNESS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                scpf_pkg::REG_TOOL_RADIUS: tool_radius_reg <= cfg_wdata;
                scpf_pkg::REG_NODE_RADIUS: node_radius_reg <= cfg_wdata;
                scpf_pkg::REG_STIFFNESS:   stiffness_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign rsum = scpf_pkg::RSUM_W'(tool_radius_reg) + scpf_pkg::RSUM_W'(node_radius_reg);

    // The pipeline moves whenever the output register is free or being taken.
    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    // Unpack the request.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tool[i] = s_tdata[i*CW +: CW];
            node[i] = s_tdata[(i+3)*CW +: CW];
        end
    end

    scpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .tool      (tool),
        .node      (node),
        .rsum      (rsum),
        .stiffness (stiffness_reg),
        .out_valid (front_valid),
        .out_geom  (front_geom)
    );

    scpf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (front_valid),
        .in_geom   (front_geom),
        .out_valid (sqrt_valid),
        .out_geom  (sqrt_geom),
        .len       (len)
    );

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        scpf_axis u_axis (
            .clk       (clk),
            .en        (pipe_en),
            .contact   (sqrt_geom.contact),
            .neg       (sqrt_geom.neg[a]),
            .mag       (sqrt_geom.mag[a]),
            .len       (len),
            .rsum      (rsum),
            .stiffness (stiffness_reg),
            .force_out (force_v[a])
        );
    end

    // Valid and contact bits alongside the axis pipelines.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[L-2:0], sqrt_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            contact_reg <= {contact_reg[L-2:0], sqrt_geom.contact};
        end
    end

    assign m_tvalid = vld_reg[L-1];
    assign m_tdata  = {7'b0, contact_reg[L-1], force_v[2], force_v[1], force_v[0]};

    // A result out of contact carries no force.
    `SCPF_ASSERT_SAME(a_zero_force, m_tvalid && !m_tdata[72], m_tdata[71:0] == 72'd0, "force without contact")

    // A held result blocks new requests.
    `SCPF_ASSERT_SAME(a_stall_blocks, m_tvalid && !m_tready, !s_tready, "request taken during stall")

    // A stalled pipeline keeps its result.
    `SCPF_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(m_tdata), "result changed during stall")

endmodule

### hw/rtl/scpf_front.sv
// ----------------------------------------------------------------------------
// scpf_front
// Difference vector, squared length and overlap test in three stages.
// ----------------------------------------------------------------------------
module scpf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][scpf_pkg::COORD_W-1:0]   tool,
    input  logic [2:0][scpf_pkg::COORD_W-1:0]   node,
    input  logic [scpf_pkg::RSUM_W-1:0]         rsum,
    input  logic [scpf_pkg::RAD_W-1:0]          stiffness,
    output logic                                out_valid,
    output scpf_pkg::geom_t                     out_geom
);

    logic [2:0]                                 vld_reg;
    logic signed [scpf_pkg::DIFF_W-1:0]         d_reg [3];
    logic [scpf_pkg::SQ_W-1:0]                  sq_reg [3];
    logic [scpf_pkg::DIFF_W-1:0]                mag_reg [3];
    logic [2:0]                                 neg_reg;
    logic [scpf_pkg::SUM_W-1:0]                 s_next;
    logic [scpf_pkg::S_W-1:0]                   rsum_sq;
    scpf_pkg::geom_t                            geom_next;
    scpf_pkg::geom_t                            geom_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // Stage 1 forms the differences, stage 2 squares them.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]   <= $signed({tool[i][scpf_pkg::COORD_W-1], tool[i]})
                            - $signed({node[i][scpf_pkg::COORD_W-1], node[i]});
                sq_reg[i]  <= scpf_pkg::SQ_W'(d_reg[i] * d_reg[i]);
                mag_reg[i] <= d_reg[i][scpf_pkg::DIFF_W-1] ?
                              scpf_pkg::DIFF_W'(-d_reg[i]) : scpf_pkg::DIFF_W'(d_reg[i]);
                neg_reg[i] <= d_reg[i][scpf_pkg::DIFF_W-1];
            end
            geom_reg <= geom_next;
        end
    end

    // Stage 3 sums the squares and tests for a strict overlap at nonzero distance and stiffness.
    always_comb
    begin
        s_next  = scpf_pkg::SUM_W'(sq_reg[0]) + scpf_pkg::SUM_W'(sq_reg[1])
                + scpf_pkg::SUM_W'(sq_reg[2]);
        rsum_sq = rsum * rsum;
        geom_next.contact = (s_next != '0) && (s_next < scpf_pkg::SUM_W'(rsum_sq))
                          && (stiffness != '0);
        geom_next.neg = neg_reg;
        for (int i = 0; i < 3; i++)
        begin
            geom_next.mag[i] = mag_reg[i][scpf_pkg::MAG_W-1:0];
        end
        geom_next.s = s_next[scpf_pkg::S_W-1:0];
    end

    assign out_valid = vld_reg[2];
    assign out_geom  = geom_reg;

endmodule

### hw/rtl/scpf_sqrt.sv
// ----------------------------------------------------------------------------
// scpf_sqrt
// Pipelined restoring square root, one result bit per stage, giving the
// center distance with eight fraction bits.
// ----------------------------------------------------------------------------
module scpf_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  scpf_pkg::geom_t                 in_geom,
    output logic                            out_valid,
    output scpf_pkg::geom_t                 out_geom,
    output logic [scpf_pkg::LEN_W-1:0]      len
);

    localparam int N = scpf_pkg::SQRT_STAGES;
    localparam int W = scpf_pkg::SQRT_W;

    typedef struct packed {
        logic [W-1:0]    v;
        logic [W-1:0]    res;
        scpf_pkg::geom_t geom;
    } sq_stage_t;

    logic [N-1:0] vld_reg;
    sq_stage_t    st_reg [N];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    // One stage per result bit, testing bit weights from the top down.
    for (genvar g = 0; g < N; g++)
    begin : g_stage
        localparam int SH = 2 * (N - 1 - g);
        sq_stage_t    cur;
        sq_stage_t    st_next;
        logic [W-1:0] trial;

        if (g == 0)
        begin : g_first
            always_comb
            begin
                cur.v    = {{(W - scpf_pkg::S_W - 16){1'b0}}, in_geom.s, 16'b0};
                cur.res  = '0;
                cur.geom = in_geom;
            end
        end
        else
        begin : g_rest
            assign cur = st_reg[g-1];
        end

        always_comb
        begin
            trial   = cur.res + (W'(1) << SH);
            st_next = cur;
            if (cur.v >= trial)
            begin
                st_next.v   = cur.v - trial;
                st_next.res = (cur.res >> 1) + (W'(1) << SH);
            end
            else
            begin
                st_next.res = cur.res >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= st_next;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_geom  = st_reg[N-1].geom;
    assign len       = st_reg[N-1].res[scpf_pkg::LEN_W-1:0];

endmodule

### hw/rtl/scpf_axis.sv
// ----------------------------------------------------------------------------
// scpf_axis
// Force along one axis: penetration, two registered multiplies, a pipelined
// restoring divider with round to nearest, and saturation.
// ----------------------------------------------------------------------------
module scpf_axis (
    input  logic                                clk,
    input  logic                                en,
    input  logic                                contact,
    input  logic                                neg,
    input  logic [scpf_pkg::MAG_W-1:0]          mag,
    input  logic [scpf_pkg::LEN_W-1:0]          len,
    input  logic [scpf_pkg::RSUM_W-1:0]         rsum,
    input  logic [scpf_pkg::RAD_W-1:0]          stiffness,
    output logic [scpf_pkg::FORCE_W-1:0]        force_out
);

    localparam int Q = scpf_pkg::DIV_STAGES;

    typedef struct packed {
        logic                           contact;
        logic                           neg;
        logic [scpf_pkg::MAG_W-1:0]     mag;
        logic [scpf_pkg::LEN_W-1:0]     len;
    } side_t;

    typedef struct packed {
        logic                           contact;
        logic                           neg;
        logic                           ovf;
        logic [scpf_pkg::REM_W-1:0]     rem;
        logic [scpf_pkg::DEN_W-1:0]     den;
        logic [Q-1:0]                   q;
    } div_t;

    side_t                          a_reg, b_reg, c_reg;
    logic [scpf_pkg::LEN_W-1:0]     pen_reg;
    logic [scpf_pkg::KP_W-1:0]      kp_reg;
    logic [scpf_pkg::NUM_W-1:0]     num_reg;
    logic [scpf_pkg::NUMER_W-1:0]   numer_reg;
    logic [scpf_pkg::DEN_W-1:0]     den_reg;
    logic                           d_contact_reg, d_neg_reg;
    div_t                           e_next;
    div_t                           dv_reg [Q+1];
    logic [scpf_pkg::FORCE_W-1:0]   force_next;
    logic [scpf_pkg::FORCE_W-1:0]   force_reg;
    logic [Q-1:0]                   lim;

    // Penetration, stiffness product, numerator, then the rounding setup.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg         <= '{contact: contact, neg: neg, mag: mag, len: len};
            pen_reg       <= scpf_pkg::LEN_W'({rsum, 8'b0} - scpf_pkg::LEN_W'(len));
            b_reg         <= a_reg;
            kp_reg        <= stiffness * pen_reg;
            c_reg         <= b_reg;
            num_reg       <= kp_reg * b_reg.mag;
            numer_reg     <= {1'b0, num_reg, 1'b0}
                           + scpf_pkg::NUMER_W'({c_reg.len, 12'b0});
            den_reg       <= {c_reg.len, 13'b0};
            d_contact_reg <= c_reg.contact;
            d_neg_reg     <= c_reg.neg;
            dv_reg[0]     <= e_next;
        end
    end

    // A quotient that needs more than the output bits saturates.
    always_comb
    begin
        e_next.contact = d_contact_reg;
        e_next.neg     = d_neg_reg;
        e_next.rem     = scpf_pkg::REM_W'(numer_reg);
        e_next.den     = den_reg;
        e_next.q       = '0;
        e_next.ovf     = scpf_pkg::REM_W'(numer_reg) >= {den_reg, {Q{1'b0}}};
    end

    // One quotient bit per stage, from the top bit down.
    for (genvar g = 0; g < Q; g++)
    begin : g_div
        localparam int SH = Q - 1 - g;
        div_t                       st_next;
        logic [scpf_pkg::REM_W-1:0] sub;

        always_comb
        begin
            sub     = scpf_pkg::REM_W'(dv_reg[g].den) << SH;
            st_next = dv_reg[g];
            if (dv_reg[g].rem >= sub)
            begin
                st_next.rem   = dv_reg[g].rem - sub;
                st_next.q[SH] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[g+1] <= st_next;
            end
        end
    end

    // Saturate, apply the sign, and force zero outside contact.
    always_comb
    begin
        lim = dv_reg[Q].q;
        if (dv_reg[Q].neg)
        begin
            if (dv_reg[Q].ovf || (dv_reg[Q].q > (Q'(1) << (Q - 1))))
            begin
                lim = Q'(1) << (Q - 1);
            end
            force_next = scpf_pkg::FORCE_W'(-lim);
        end
        else
        begin
            if (dv_reg[Q].ovf || dv_reg[Q].q[Q-1])
            begin
                lim = (Q'(1) << (Q - 1)) - Q'(1);
            end
            force_next = scpf_pkg::FORCE_W'(lim);
        end
        if (!dv_reg[Q].contact)
        begin
            force_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            force_reg <= force_next;
        end
    end

    assign force_out = force_reg;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams tool/node center pairs into the sphere contact force block under
// several radius and stiffness settings, predicts each force vector with an
// integer model and compares every returned request field by field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [scpf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 70;

    typedef struct packed {
        logic                          contact;
        logic [scpf_pkg::FORCE_W-1:0]  fz;
        logic [scpf_pkg::FORCE_W-1:0]  fy;
        logic [scpf_pkg::FORCE_W-1:0]  fx;
    } force_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [scpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [scpf_pkg::RAD_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [111:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [79:0] m_tdata;

    // Register copies used by the force predictor.
    logic [scpf_pkg::RAD_W-1:0] tool_r = scpf_pkg::TOOL_RADIUS_RST;
    logic [scpf_pkg::RAD_W-1:0] node_r = scpf_pkg::NODE_RADIUS_RST;
    logic [scpf_pkg::RAD_W-1:0] stiff = scpf_pkg::STIFFNESS_RST;

    logic [111:0] pair_queue[$];
    force_t expected_forces[$];
    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_contacts = 0;
    int n_errors = 0;
    int cycles = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    sphere_contact_penalty_force dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Force along one axis: rounded half away from zero, then saturated.
    function automatic logic [scpf_pkg::FORCE_W-1:0] axis_force(longint d,
                                                                longint unsigned pen,
                                                                longint unsigned len);
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        mag = (d < 0) ? -d : d;
        num = longint'(stiff) * pen * mag;
        den = len * 4096;
        q = (num * 2 + den) / (den * 2);
        if (d < 0)
        begin
            if (q > 8388608)
                q = 8388608;
            return scpf_pkg::FORCE_W'(-q);
        end
        if (q > 8388607)
            q = 8388607;
        return scpf_pkg::FORCE_W'(q);
    endfunction

    function automatic force_t contact_force(logic [111:0] pair);
        longint d[3];
        longint unsigned s;
        longint unsigned rsum;
        longint unsigned len;
        longint unsigned pen;
        force_t f;
        for (int a = 0; a < 3; a++)
            d[a] = longint'($signed(pair[a*18 +: 18])) - longint'($signed(pair[(a+3)*18 +: 18]));
        s = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
        rsum = longint'(tool_r) + longint'(node_r);
        f = '0;
        if (s == 0 || s >= rsum * rsum || stiff == 0)
            return f;
        len = int_sqrt(s << 16);
        pen = (rsum << 8) - len;
        f.fx = axis_force(d[0], pen, len);
        f.fy = axis_force(d[1], pen, len);
        f.fz = axis_force(d[2], pen, len);
        f.contact = 1'b1;
        return f;
    endfunction

    function automatic logic [111:0] make_pair(logic [17:0] t[3], longint d[3]);
        logic [111:0] p;
        p = '0;
        for (int a = 0; a < 3; a++)
        begin
            p[a*18 +: 18] = t[a];
            p[(a+3)*18 +: 18] = 18'(longint'($signed(t[a])) - d[a]);
        end
        return p;
    endfunction

    task automatic add_pair(logic [17:0] t[3], longint d[3]);
        pair_queue.push_back(make_pair(t, d));
        n_queued++;
    endtask

    // Edge cases around the present radius sum.
    task automatic add_directed();
        logic [17:0] t[3];
        longint d[3];
        longint r;
        r = longint'(tool_r) + longint'(node_r);
        t = '{18'h1ffff, 18'h1ffff, 18'h1ffff};
        d = '{-131071, -131071, -131071};
        pair_queue.push_back({4'b0, {3{18'h20000}}, {3{18'h1ffff}}});
        pair_queue.push_back({4'b0, {3{18'h1ffff}}, {3{18'h20000}}});
        n_queued += 2;
        t = '{18'h0, 18'h0, 18'h0};
        d = '{0, 0, 0};
        add_pair(t, d);                        // coincident centers
        t = '{18'h12345, 18'h2abcd, 18'h00f0f};
        add_pair(t, d);
        for (int a = 0; a < 3; a++)
        begin
            d = '{0, 0, 0};
            d[a] = r;     add_pair(t, d);      // just touching
            d[a] = r - 1; add_pair(t, d);      // barely overlapping
            d[a] = -(r - 1); add_pair(t, d);
            d[a] = 1;     add_pair(t, d);      // deep overlap
            d[a] = -1;    add_pair(t, d);
        end
        d = '{r / 2, -(r / 3), r / 4};
        add_pair(t, d);
        d = '{-1, 1, -1};
        add_pair(t, d);
    endtask

    task automatic add_random(int count);
        logic [17:0] t[3];
        longint d[3];
        longint r;
        int mode;
        r = longint'(tool_r) + longint'(node_r);
        for (int i = 0; i < count; i++)
        begin
            mode = $urandom_range(0, 99);
            for (int a = 0; a < 3; a++)
            begin
                t[a] = 18'($urandom);
                if (mode < 75)
                    d[a] = longint'($urandom_range(0, 2 * r)) - r;
                else if (mode < 88)
                    d[a] = longint'($urandom_range(0, 6)) - 3;
                else
                    d[a] = longint'($signed(t[a])) - longint'($signed(18'($urandom)));
            end
            add_pair(t, d);
        end
    endtask

    task automatic write_reg(logic [scpf_pkg::CFG_IDX_W-1:0] idx,
                             logic [scpf_pkg::RAD_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == scpf_pkg::REG_TOOL_RADIUS)
            tool_r = val;
        else if (idx == scpf_pkg::REG_NODE_RADIUS)
            node_r = val;
        else if (idx == scpf_pkg::REG_STIFFNESS)
            stiff = val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold further requests until every result is back, then let the pipe drain.
    task automatic wait_idle();
        wait (n_accepted == n_queued && expected_forces.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic setup(logic [scpf_pkg::RAD_W-1:0] tr, logic [scpf_pkg::RAD_W-1:0] nr,
                         logic [scpf_pkg::RAD_W-1:0] k);
        write_reg(scpf_pkg::REG_TOOL_RADIUS, tr);
        write_reg(scpf_pkg::REG_NODE_RADIUS, nr);
        write_reg(scpf_pkg::REG_STIFFNESS, k);
    endtask

    // Sender: the next request may go out once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pair_queue.size() != 0 && !hold_off && (calm || $urandom_range(0, 99) >= 34))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= pair_queue.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Predict at acceptance.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_forces.push_back(contact_force(s_tdata));
            n_accepted++;
        end
    end

    // Receiver: random stalls and comparison.
    always @(posedge clk or negedge rst_n)
    begin
        force_t exp_f;
        force_t got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= 34);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[72:0];
                n_results++;
                if (expected_forces.size() == 0)
                begin
                    $error("unexpected result request %h", m_tdata);
                    n_errors++;
                end
                else
                begin
                    exp_f = expected_forces.pop_front();
                    if (got.contact)
                        n_contacts++;
                    if (got.fx !== exp_f.fx)
                    begin
                        $error("force_x expected %h got %h", exp_f.fx, got.fx);
                        n_errors++;
                    end
                    if (got.fy !== exp_f.fy)
                    begin
                        $error("force_y expected %h got %h", exp_f.fy, got.fy);
                        n_errors++;
                    end
                    if (got.fz !== exp_f.fz)
                    begin
                        $error("force_z expected %h got %h", exp_f.fz, got.fz);
                        n_errors++;
                    end
                    if (got.contact !== exp_f.contact)
                    begin
                        $error("in_contact expected %b got %b", exp_f.contact, got.contact);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of the registers.
        add_directed();
        add_random(250);
        wait_idle();

        // Largest radii and stiffness: saturation, no idling in this phase.
        setup(16'hffff, 16'hffff, 16'hffff);
        calm = 1'b1;
        add_directed();
        add_random(200);
        wait_idle();
        calm = 1'b0;

        // Zero radii never touch.
        setup(16'h0, 16'h0, 16'd1000);
        add_directed();
        add_random(60);
        wait_idle();

        // Zero stiffness; a write to the unused index must change nothing.
        setup(16'd3000, 16'd100, 16'h0);
        write_reg(REG_UNUSED, 16'hffff);
        add_directed();
        add_random(60);
        wait_idle();

        // Random settings.
        for (int p = 0; p < 4; p++)
        begin
            setup(16'($urandom), 16'($urandom), 16'($urandom));
            add_random(100);
            wait_idle();
        end

        $display("tb: %0d pairs sent, %0d results checked, %0d in contact", n_accepted,
                 n_results, n_contacts);
        $display("tb: configs covered reset, max, zero radius, zero stiffness, random");
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### sphere_contact_penalty_force.f
+incdir+hw/rtl
hw/rtl/scpf_pkg.sv
hw/rtl/scpf_front.sv
hw/rtl/scpf_sqrt.sv
hw/rtl/scpf_axis.sv
hw/rtl/sphere_contact_penalty_force.sv
tb/sv/testbench.sv
